// ----- hdl/rse_pkg.sv -----
// Shared types and constants for the RS(255,241) encoder.
// Holds item structs, the generator polynomial and the GF(256) multiply.
// No dependencies.
`default_nettype none

package rse_pkg;

    // Number of parity symbols per codeword
    localparam int PARITY_COUNT = 14;
    localparam int CNT_W        = $clog2(PARITY_COUNT);

    // Field polynomial x^8+x^4+x^3+x^2+1, low eight bits
    localparam logic [7:0] FIELD_POLY_LO = 8'h1D;

    // Generator coefficients, x^14 first
    localparam logic [7:0] GEN_POLY [0:PARITY_COUNT] = '{
        8'd1,   8'd28,  8'd216, 8'd183, 8'd20,  8'd100, 8'd46, 8'd36,
        8'd77,  8'd36,  8'd175, 8'd43,  8'd188, 8'd156, 8'd26
    };

    typedef struct packed {
        logic [7:0] message_byte;
        logic       final_symbol;
    } msg_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       is_parity;
        logic       end_of_codeword;
    } code_item_t;

    // Per-cycle control shared by every cell of the remainder chain
    typedef struct packed {
        logic       advance;
        logic [7:0] feedback;
    } cell_ctrl_t;

    // Shift-and-add multiply in GF(256); folds to XORs for a constant operand
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        logic       carry;
        x   = a;
        acc = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            carry = x[7];
            x     = {x[6:0], 1'b0};
            if (carry) begin
                x = x ^ FIELD_POLY_LO;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rse_cell.sv -----
// One remainder cell of the encoder's division chain.
// Uses rse_pkg for the control struct and the GF(256) multiply.
`default_nettype none

module rse_cell #(
    parameter logic [7:0] COEF = 8'd1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rse_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]        shift_in,
    output logic [7:0]             value
);

    logic [7:0] value_reg;
    logic [7:0] value_next;

    // Take the neighbor's byte plus this cell's share of the feedback
    assign value_next = shift_in ^ rse_pkg::gf_mul(ctrl.feedback, COEF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= 8'd0;
        end
        else if (ctrl.advance)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ----- hdl/rse_obuf.sv -----
// Two-entry output buffer that parts the encoder core from the output stall.
// Uses rse_pkg for the output item type.
`default_nettype none

module rse_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rse_pkg::code_item_t push_item,
    output logic                   full,
    output logic                   code_valid,
    input  wire logic              code_stall,
    output rse_pkg::code_item_t    code
);

    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    rse_pkg::code_item_t head_reg;
    rse_pkg::code_item_t head_next;
    rse_pkg::code_item_t tail_reg;
    rse_pkg::code_item_t tail_next;
    logic                pop;

    assign pop = code_valid && !code_stall;

    // Advance the two entries on pop and push
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = push_item;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = push_item;
            end
        end
        else if (pop)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_next = push_item;
            end
            else
            begin
                tail_next = push_item;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full       = (count_reg == 2'd2);
    assign code_valid = (count_reg != 2'd0);
    assign code       = head_reg;

endmodule

`default_nettype wire

// ----- hdl/reed_solomon_encoder_core.sv -----
// Top level of the systematic RS(255,241) encoder over GF(256).
// Depends on rse_pkg, rse_cell and rse_obuf.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+------------------------------
//   input   | msg_valid  | msg_stall  | msg  (rse_pkg::msg_item_t)
//   output  | code_valid | code_stall | code (rse_pkg::code_item_t)
//
// A message item is taken every cycle that msg_stall is low and passed on to the
// output buffer. After the item marked final, 14 parity items follow, one per
// cycle if the buffer has room; msg_stall holds while the chain shifts them out.
// The chain clears itself while draining, so the next codeword starts at once.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset clears the chain, the drain counter and the buffer.
`default_nettype none

module reed_solomon_encoder_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             msg_valid,
    output logic                  msg_stall,
    input  wire rse_pkg::msg_item_t msg,
    output logic                  code_valid,
    input  wire logic             code_stall,
    output rse_pkg::code_item_t   code
);

    localparam int PC = rse_pkg::PARITY_COUNT;
    localparam int CW = rse_pkg::CNT_W;

    logic                        accept;
    logic                        buf_full;
    logic                        drain_step;
    logic                        drain_last;
    logic                        push;
    rse_pkg::code_item_t         push_item;
    rse_pkg::cell_ctrl_t         ctrl;
    logic [PC-1:0][7:0]          rem;
    logic                        draining_reg;
    logic                        draining_next;
    logic [CW-1:0]               drain_cnt_reg;
    logic [CW-1:0]               drain_cnt_next;

    assign msg_stall  = draining_reg || buf_full;
    assign accept     = msg_valid && !msg_stall;
    assign drain_step = draining_reg && !buf_full;
    assign drain_last = (drain_cnt_reg == CW'(PC - 1));
    assign push       = accept || drain_step;

    // Feed the chain on a message item; shift with zero feedback while draining
    assign ctrl.advance  = push;
    assign ctrl.feedback = accept ? (msg.message_byte ^ rem[0]) : 8'd0;

    // Pick the item for the output buffer
    always_comb
    begin
        if (accept)
        begin
            push_item.code_byte       = msg.message_byte;
            push_item.is_parity       = 1'b0;
            push_item.end_of_codeword = 1'b0;
        end
        else
        begin
            push_item.code_byte       = rem[0];
            push_item.is_parity       = 1'b1;
            push_item.end_of_codeword = drain_last;
        end
    end

    // Remainder chain: cell j takes cell j+1 and the feedback times g[j+1]
    for (genvar j = 0; j < PC; j++)
    begin : g_cell
        logic [7:0] neighbor;
        if (j == PC - 1)
        begin : g_end
            assign neighbor = 8'd0;
        end
        else
        begin : g_mid
            assign neighbor = rem[j+1];
        end
        rse_cell #(
            .COEF (rse_pkg::GEN_POLY[j+1])
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .shift_in (neighbor),
            .value    (rem[j])
        );
    end

    // Drain control: start on the final item, stop after the last parity item
    always_comb
    begin
        draining_next  = draining_reg;
        drain_cnt_next = drain_cnt_reg;
        if (accept && msg.final_symbol)
        begin
            draining_next  = 1'b1;
            drain_cnt_next = '0;
        end
        else if (drain_step)
        begin
            if (drain_last)
            begin
                draining_next = 1'b0;
            end
            else
            begin
                drain_cnt_next = drain_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg  <= 1'b0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            draining_reg  <= draining_next;
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    rse_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (buf_full),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

    // A final item always starts a drain
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && msg.final_symbol |=> draining_reg)
        else $error("drain did not start after final item");

    // The chain is empty once the last parity item has gone
    assert property (@(posedge clk) disable iff (!rst_n)
        drain_step && drain_last |=> (rem == '0))
        else $error("remainder not cleared after drain");

    // Never push into a full buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !buf_full)
        else $error("push into full output buffer");

    // End of codeword is only ever flagged on a parity item
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code.end_of_codeword |-> code.is_parity)
        else $error("end of codeword on a message item");

endmodule

`default_nettype wire
